// ===== sv/bba_pkg.sv =====
// Buddy block allocator: shared types and codes.
// Used by bba_ctrl, bba_dpath and buddy_block_allocator. No dependencies.
package bba_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;
    localparam int EW          = 6;

    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_ZERO     = 3'd1;
    localparam logic [2:0] RC_TOO_BIG  = 3'd2;
    localparam logic [2:0] RC_NO_FREE  = 3'd3;
    localparam logic [2:0] RC_BAD_FREE = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_A_EXP, S_SCAN_RD, S_SCAN_EV, S_UP_RD, S_UP_EV,
        S_UP_TEST, S_PAIR_RD, S_PAIR_EV, S_MARK_RD, S_MARK_EV, S_F_TZ, S_F_CHK, S_F_RD,
        S_F_EV, S_DN_TEST, S_DN_EV, S_RT_RD, S_RT_EV, S_CLR_WR, S_CLR_RD, S_CLR_EV,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_E_INC, OP_E_MAX, OP_A_SETUP, OP_I_NEXT, OP_GO_UP,
        OP_MARK_START, OP_GO_DN, OP_F_SETUP, OP_F_SIZE, OP_ADD_RES, OP_SUB_RES,
        OP_EMIT, OP_CLR_STEP
    } dp_op_t;

    typedef enum logic [2:0] {
        SEL_CUR, SEL_PARENT, SEL_PAIR, SEL_LCHILD, SEL_RCHILD, SEL_SWEEP
    } addr_sel_t;

    typedef struct packed {
        dp_op_t     op;
        addr_sel_t  sel;
        logic       rd;
        logic       wr;
        logic       wval;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic rel_zero;
        logic exp_more;
        logic e_big;
        logic tz_more;
        logic f_bad;
        logic mark;
        logic i_last;
        logic nl_zero;
        logic nl_deep;
        logic clr_last;
        logic out_full;
    } dp_stat_t;

endpackage

// ===== sv/bba_ctrl.sv =====
// Buddy block allocator controller: sequences tree scans, marking and freeing.
// Depends on bba_pkg; drives bba_dpath through command/status structs.
module bba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bba_pkg::dp_stat_t stat,
    output bba_pkg::dp_cmd_t  cmd
);
    import bba_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            code_reg  <= RC_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        s_tready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.sel    = SEL_CUR;
        cmd.rd     = 1'b0;
        cmd.wr     = 1'b0;
        cmd.wval   = 1'b0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.sel = SEL_SWEEP;
                cmd.wr  = 1'b1;
                cmd.op  = OP_CLR_STEP;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.is_free) begin
                    state_next = S_F_TZ;
                end else if (stat.size_zero) begin
                    code_next  = RC_ZERO;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_A_EXP;
                end
            end
            S_A_EXP: begin
                if (stat.exp_more) begin
                    cmd.op = OP_E_INC;
                end else if (stat.e_big) begin
                    code_next  = RC_TOO_BIG;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_A_SETUP;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (stat.mark) begin
                    if (stat.i_last) begin
                        code_next  = RC_NO_FREE;
                        state_next = S_EMIT;
                    end else begin
                        cmd.op     = OP_I_NEXT;
                        state_next = S_SCAN_RD;
                    end
                end else if (stat.nl_zero) begin
                    cmd.op     = OP_MARK_START;
                    state_next = S_MARK_RD;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD: begin
                cmd.sel    = SEL_PARENT;
                cmd.rd     = 1'b1;
                state_next = S_UP_EV;
            end
            S_UP_EV: begin
                if (stat.mark) begin
                    state_next = S_PAIR_RD;
                end else begin
                    cmd.op     = OP_GO_UP;
                    state_next = S_UP_TEST;
                end
            end
            S_UP_TEST: begin
                if (stat.nl_zero) begin
                    cmd.op     = OP_MARK_START;
                    state_next = S_MARK_RD;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_PAIR_RD: begin
                cmd.sel    = SEL_PAIR;
                cmd.rd     = 1'b1;
                state_next = S_PAIR_EV;
            end
            S_PAIR_EV: begin
                if (stat.mark) begin
                    cmd.op     = OP_MARK_START;
                    state_next = S_MARK_RD;
                end else if (stat.i_last) begin
                    code_next  = RC_NO_FREE;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_I_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_MARK_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_MARK_EV;
            end
            S_MARK_EV: begin
                if (stat.mark) begin
                    cmd.op     = OP_ADD_RES;
                    code_next  = RC_OK;
                    state_next = S_EMIT;
                end else begin
                    cmd.wr   = 1'b1;
                    cmd.wval = 1'b1;
                    if (stat.nl_zero) begin
                        cmd.op     = OP_ADD_RES;
                        code_next  = RC_OK;
                        state_next = S_EMIT;
                    end else begin
                        cmd.op     = OP_GO_UP;
                        state_next = S_MARK_RD;
                    end
                end
            end
            S_F_TZ: begin
                if (stat.rel_zero) begin
                    cmd.op     = OP_E_MAX;
                    state_next = S_F_CHK;
                end else if (stat.tz_more) begin
                    cmd.op = OP_E_INC;
                end else begin
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (stat.f_bad) begin
                    code_next  = RC_BAD_FREE;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_F_SETUP;
                    state_next = S_F_RD;
                end
            end
            S_F_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_F_EV;
            end
            S_F_EV: begin
                if (stat.mark) begin
                    state_next = S_DN_TEST;
                end else begin
                    code_next  = RC_BAD_FREE;
                    state_next = S_EMIT;
                end
            end
            S_DN_TEST: begin
                if (stat.nl_deep) begin
                    cmd.op     = OP_F_SIZE;
                    state_next = S_CLR_WR;
                end else begin
                    cmd.sel    = SEL_LCHILD;
                    cmd.rd     = 1'b1;
                    state_next = S_DN_EV;
                end
            end
            S_DN_EV: begin
                if (stat.mark) begin
                    cmd.op     = OP_GO_DN;
                    state_next = S_DN_TEST;
                end else begin
                    state_next = S_RT_RD;
                end
            end
            S_RT_RD: begin
                cmd.sel    = SEL_RCHILD;
                cmd.rd     = 1'b1;
                state_next = S_RT_EV;
            end
            S_RT_EV: begin
                if (stat.mark) begin
                    code_next  = RC_BAD_FREE;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_F_SIZE;
                    state_next = S_CLR_WR;
                end
            end
            S_CLR_WR: begin
                cmd.wr = 1'b1;
                if (stat.nl_zero) begin
                    cmd.op     = OP_SUB_RES;
                    code_next  = RC_OK;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_CLR_RD;
                end
            end
            S_CLR_RD: begin
                cmd.sel    = SEL_PAIR;
                cmd.rd     = 1'b1;
                state_next = S_CLR_EV;
            end
            S_CLR_EV: begin
                if (stat.mark) begin
                    cmd.op     = OP_SUB_RES;
                    code_next  = RC_OK;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_GO_UP;
                    state_next = S_CLR_WR;
                end
            end
            S_EMIT: begin
                if (!stat.out_full) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/bba_dpath.sv =====
// Buddy block allocator datapath: node mark memory, tree cursor, counters,
// reserved total and result register. Depends on bba_pkg; driven by bba_ctrl.
module bba_dpath #(
    parameter int MIN_EXP = 12,
    parameter int MAX_EXP = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bba_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bba_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  bba_pkg::dp_cmd_t                    cmd,
    output bba_pkg::dp_stat_t                   stat
);
    import bba_pkg::*;

    localparam int D     = MAX_EXP - MIN_EXP;
    localparam int AW    = D + 1;
    localparam int DEPTH = 1 << AW;
    localparam int LW    = (D < 1) ? 1 : $clog2(D + 1);
    localparam int NW    = (D < 1) ? 1 : D;
    localparam int IW    = D + 1;

    logic          mark_mem [DEPTH];
    logic          rdata_reg;
    logic          mode_reg;
    logic [31:0]   size_reg;
    logic [19:0]   rel_reg;
    logic [EW-1:0] e_reg;
    logic [LW-1:0] lvl_reg;
    logic [IW-1:0] i_reg;
    logic [LW-1:0] nl_reg;
    logic [NW-1:0] ni_reg;
    logic [AW-1:0] clr_reg;
    logic [20:0]   res_reg;
    logic          m_tvalid_reg;
    logic [71:0]   out_reg;

    logic [LW-1:0] a_lvl;
    logic [NW-1:0] a_idx;
    logic [AW-1:0] addr;
    logic [EW-1:0] e_eff;
    logic [20:0]   bsz21;
    logic [63:0]   alloc_off;
    logic [63:0]   rel_sh;
    logic [IW-1:0] i_max;
    logic [19:0]   ok_off;

    always_comb begin
        a_lvl = nl_reg;
        a_idx = ni_reg;
        case (cmd.sel)
            SEL_PARENT: begin
                a_lvl = nl_reg - LW'(1);
                a_idx = ni_reg >> 1;
            end
            SEL_PAIR:   a_idx = ni_reg ^ NW'(1);
            SEL_LCHILD: begin
                a_lvl = nl_reg + LW'(1);
                a_idx = ni_reg << 1;
            end
            SEL_RCHILD: begin
                a_lvl = nl_reg + LW'(1);
                a_idx = (ni_reg << 1) | NW'(1);
            end
            default: ;
        endcase
        if (cmd.sel == SEL_SWEEP) addr = clr_reg;
        else addr = (AW'(1) << a_lvl) - AW'(1) + AW'(a_idx);
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) mark_mem[addr] <= cmd.wval;
        if (cmd.rd) rdata_reg <= mark_mem[addr];
    end

    assign e_eff     = (e_reg < EW'(MIN_EXP)) ? EW'(MIN_EXP) : e_reg;
    assign bsz21     = (e_reg < EW'(21)) ? (21'd1 << e_reg) : 21'd0;
    assign alloc_off = 64'(i_reg) << e_reg;
    assign rel_sh    = 64'(rel_reg) >> e_reg;
    assign i_max     = (IW'(1) << lvl_reg) - IW'(1);
    assign ok_off    = mode_reg ? rel_reg : alloc_off[19:0];

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                mode_reg <= s_tdata[0];
                size_reg <= s_tdata[32:1];
                rel_reg  <= s_tdata[52:33];
                e_reg    <= '0;
            end
            OP_E_INC: e_reg <= e_reg + EW'(1);
            OP_E_MAX: e_reg <= EW'(MAX_EXP);
            OP_A_SETUP: begin
                e_reg   <= e_eff;
                lvl_reg <= LW'(MAX_EXP - int'(e_eff));
                nl_reg  <= LW'(MAX_EXP - int'(e_eff));
                i_reg   <= '0;
                ni_reg  <= '0;
            end
            OP_I_NEXT: begin
                i_reg  <= i_reg + IW'(1);
                ni_reg <= NW'(i_reg + IW'(1));
                nl_reg <= lvl_reg;
            end
            OP_GO_UP: begin
                nl_reg <= nl_reg - LW'(1);
                ni_reg <= ni_reg >> 1;
            end
            OP_MARK_START: begin
                nl_reg <= lvl_reg;
                ni_reg <= NW'(i_reg);
            end
            OP_GO_DN: begin
                nl_reg <= nl_reg + LW'(1);
                ni_reg <= ni_reg << 1;
            end
            OP_F_SETUP: begin
                lvl_reg <= LW'(MAX_EXP - int'(e_reg));
                nl_reg  <= LW'(MAX_EXP - int'(e_reg));
                ni_reg  <= NW'(rel_sh);
            end
            OP_F_SIZE: e_reg <= EW'(MAX_EXP - int'(nl_reg));
            OP_EMIT: begin
                out_reg[2:0]   <= cmd.code;
                out_reg[22:3]  <= (cmd.code == RC_OK) ? ok_off : 20'd0;
                out_reg[43:23] <= (cmd.code == RC_OK) ? bsz21 : 21'd0;
                out_reg[64:44] <= res_reg;
                out_reg[71:65] <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            res_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_CLR_STEP) clr_reg <= clr_reg + AW'(1);
            if (cmd.op == OP_ADD_RES) res_reg <= res_reg + bsz21;
            if (cmd.op == OP_SUB_RES) begin
                if (e_reg >= EW'(21) || res_reg < bsz21) res_reg <= '0;
                else res_reg <= res_reg - bsz21;
            end
            if (cmd.op == OP_EMIT) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    assign stat.is_free   = mode_reg;
    assign stat.size_zero = (size_reg == 32'd0);
    assign stat.rel_zero  = (rel_reg == 20'd0);
    assign stat.exp_more  = (e_reg < EW'(32)) && ((33'd1 << e_reg) < {1'b0, size_reg});
    assign stat.e_big     = (e_reg > EW'(MAX_EXP));
    assign stat.tz_more   = (e_reg < EW'(20)) && !rel_sh[0];
    assign stat.f_bad     = (e_reg < EW'(MIN_EXP)) || (e_reg > EW'(MAX_EXP))
                            || ((64'(rel_reg) >> MAX_EXP) != 64'd0);
    assign stat.mark      = rdata_reg;
    assign stat.i_last    = (i_reg == i_max);
    assign stat.nl_zero   = (nl_reg == '0);
    assign stat.nl_deep   = (nl_reg == LW'(D));
    assign stat.clr_last  = &clr_reg;
    assign stat.out_full  = m_tvalid_reg && !m_tready;

endmodule

// ===== sv/buddy_block_allocator.sv =====
// Buddy block allocator over a pool of 2^MAX_EXP bytes.
// Instantiates bba_ctrl and bba_dpath; depends on bba_pkg.
//
// One request word in on s_*, one result word out on m_* per request.
// Requests allocate (rounded up to a power of two, at least 2^MIN_EXP)
// or free a block by offset. The result carries a status code, the block
// offset and size, and the running total of reserved bytes.
// One request at a time; each mark read has a read state and an evaluate state.
// Allocate: accept and decode, round the size up, then scan the nodes on the target
// level in order; for a free node walk up through its free ancestors and, at a
// marked ancestor, read the buddy of the last free node; marking then walks up
// one level at a time to a marked node or the root, and the result is loaded.
// Free: find the offset's alignment, check it, read the node, descend through
// marked left children, read the right child, then clear upward to a marked buddy.
// After reset the mark memory is swept clear, one node per cycle, across all
// 2^(MAX_EXP-MIN_EXP+1) nodes with s_tready low.
// The result sits in an output register; the next request is accepted while
// it waits, and the following result holds off until m_tready takes it.
module buddy_block_allocator #(
    parameter int MIN_EXP = 12,
    parameter int MAX_EXP = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode[0], request_size[32:1], free_offset[52:33]
    input  logic [bba_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[2:0], block_offset[22:3], block_size[43:23], reserved_total[64:44]
    output logic [bba_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import bba_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dpath #(
        .MIN_EXP (MIN_EXP),
        .MAX_EXP (MAX_EXP)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== tb/sv/tb_buddy_block_allocator.sv =====
// Testbench for buddy_block_allocator: allocate/free stream with a tree-based
// allocation model predicting each result word. Depends on bba_pkg and the RTL.
module tb_buddy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam int MINE = 12;
    localparam int MAXE = 20;
    localparam int DEEP = MAXE - MINE;
    localparam int NNODES = 1 << (DEEP + 1);
    localparam longint LIMIT = 20000000;

    typedef struct packed {
        logic [20:0] total;
        logic [20:0] size;
        logic [19:0] offset;
        logic [2:0]  status;
    } result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    buddy_block_allocator DUT (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    bit      tree_mark [NNODES];
    int      pool_used;
    result_t expected_q[$];
    int      errors = 0;
    int      n_results = 0;
    longint  cycles = 0;
    bit      rx_idle_on = 1;
    bit      tx_idle_on = 1;
    int      rx_hold = 0;
    logic [19:0] live_q[$];

    function automatic bit mk(int lvl, int idx);
        if (lvl < 0 || lvl > DEEP || idx < 0 || idx >= (1 << lvl)) return 0;
        return tree_mark[(1 << lvl) - 1 + idx];
    endfunction

    function automatic void setmk(int lvl, int idx, bit v);
        if (lvl < 0 || lvl > DEEP || idx < 0 || idx >= (1 << lvl)) return;
        tree_mark[(1 << lvl) - 1 + idx] = v;
    endfunction

    function automatic result_t predict_alloc(logic [31:0] size);
        result_t r;
        int e, lvl, i, n, up, j, k;
        bit found;
        r = '0;
        found = 0;
        if (size == 0) begin
            r.status = RC_ZERO;
        end else begin
            e = 0;
            while (e < 32 && (64'd1 << e) < size) e++;
            if (e > MAXE) begin
                r.status = RC_TOO_BIG;
            end else begin
                if (e < MINE) e = MINE;
                lvl = MAXE - e;
                n = 1 << lvl;
                for (i = 0; i < n && !found; i++) begin
                    if (!mk(lvl, i)) begin
                        up = lvl;
                        j = i;
                        while (up > 0 && !mk(up - 1, j / 2)) begin
                            up--;
                            j /= 2;
                        end
                        if (up == 0 || mk(up, j ^ 1)) begin
                            found = 1;
                            k = i;
                        end
                    end
                end
                if (!found) begin
                    r.status = RC_NO_FREE;
                end else begin
                    r.offset = 20'(k << e);
                    r.size = 21'(1 << e);
                    j = k;
                    up = lvl;
                    while (up >= 0 && !mk(up, j)) begin
                        setmk(up, j, 1);
                        up--;
                        j /= 2;
                    end
                    pool_used = (pool_used + (1 << e)) & 21'h1FFFFF;
                    r.status = RC_OK;
                end
            end
        end
        r.total = 21'(pool_used);
        return r;
    endfunction

    function automatic result_t predict_free(logic [19:0] rel);
        result_t r;
        int e, lvl, i, bsz;
        r = '0;
        e = 0;
        if (rel == 0) e = MAXE;
        else while (rel[e] == 0) e++;
        r.status = RC_BAD_FREE;
        if (e >= MINE) begin
            lvl = MAXE - e;
            i = rel >> e;
            if (i < (1 << lvl) && mk(lvl, i)) begin
                while (mk(lvl + 1, i * 2)) begin
                    lvl++;
                    i *= 2;
                end
                if (!mk(lvl + 1, i * 2 + 1)) begin
                    bsz = 1 << (MAXE - lvl);
                    while (lvl >= 0) begin
                        setmk(lvl, i, 0);
                        if (mk(lvl, i ^ 1)) break;
                        lvl--;
                        i /= 2;
                    end
                    pool_used = (pool_used >= bsz) ? pool_used - bsz : 0;
                    r.status = RC_OK;
                    r.offset = rel;
                    r.size = 21'(bsz);
                end
            end
        end
        r.total = 21'(pool_used);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d want %0d", n_results, what, got, want);
    endtask

    task automatic send_word(bit mode, logic [31:0] size, logic [19:0] off);
        result_t r;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        r = mode ? predict_free(off) : predict_alloc(size);
        if (!mode && r.status == RC_OK) live_q.push_back(r.offset);
        expected_q.push_back(r);
        s_tdata = {3'b0, off, size, mode};
        s_tvalid = 1;
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    always @(posedge aclk) begin
        result_t got, want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[64:0];
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.offset !== want.offset) report_mismatch("offset", got.offset, want.offset);
                if (got.size !== want.size) report_mismatch("size", got.size, want.size);
                if (got.total !== want.total) report_mismatch("total", got.total, want.total);
            end
            n_results++;
        end
    end

    always @(negedge aclk) begin
        if (!rx_idle_on) begin
            rx_hold = 0;
            m_tready <= 1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 8);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    task automatic drain();
        while (expected_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 4096);
            1: return $urandom_range(1, 1 << 14);
            2: return $urandom_range(1, 1 << 17);
            3: return $urandom_range(1, 1 << 20);
            4: return $urandom();
            default: return $urandom_range(1, 1 << 13);
        endcase
    endfunction

    task automatic test_directed();
        send_word(0, 0, 20'hFFFFF);
        send_word(0, 32'hFFFFFFFF, 0);
        send_word(0, 32'h100001, 0);
        send_word(0, 32'h100000, 0);
        send_word(0, 1, 0);
        send_word(1, 0, 0);
        send_word(1, 0, 0);
        send_word(0, 1, 0);
        send_word(0, 4097, 0);
        send_word(0, 4096, 0);
        send_word(1, 0, 20'h00800);
        send_word(1, 0, 20'h00001);
        send_word(1, 0, 20'hFF000);
        send_word(1, 0, 20'h80000);
        send_word(1, 0, 0);
        send_word(1, 0, 20'h02000);
        send_word(1, 0, 20'h01000);
        send_word(1, 0, 20'h04000);
        send_word(1, 0, 20'h03000);
        send_word(0, 32'h80000, 0);
        send_word(0, 32'h80000, 0);
        send_word(0, 32'h1000, 0);
    endtask

    task automatic test_free_all();
        int k;
        drain();
        while (live_q.size() != 0) begin
            k = $urandom_range(0, live_q.size() - 1);
            send_word(1, $urandom(), live_q[k]);
            live_q.delete(k);
        end
        send_word(1, 0, 0);
        live_q.delete();
    endtask

    task automatic test_random(int count);
        int k;
        logic [19:0] o;
        repeat (count) begin
            k = $urandom_range(0, 9);
            if (k < 5 || live_q.size() == 0) begin
                send_word(0, rand_size(), 20'($urandom()));
            end else if (k < 9) begin
                k = $urandom_range(0, live_q.size() - 1);
                o = live_q[k];
                live_q.delete(k);
                send_word(1, $urandom(), o);
            end else begin
                o = 20'($urandom());
                if ($urandom_range(0, 1)) o[11:0] = 0;
                send_word(1, $urandom(), o);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        test_directed();
        test_free_all();
        test_random(300);
        drain();
        test_free_all();
        test_random(250);
        rx_idle_on = 0;
        tx_idle_on = 0;
        test_random(120);
        drain();
        repeat (200) @(negedge aclk);
        $display("Ran %0d results: directed edge cases, pool fill/empty, random alloc/free.",
                 n_results);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/bba_pkg.sv
sv/bba_ctrl.sv
sv/bba_dpath.sv
sv/buddy_block_allocator.sv
tb/sv/tb_buddy_block_allocator.sv
